// ----- hdl/svmsl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// svmsl_pkg
// Shared widths, frame type and the tanh table for the stereo voice mixer
// with soft limiter.
// ----------------------------------------------------------------------------
package svmsl_pkg;

  localparam int SumW = 40;
  localparam int SmpW = 16;
  localparam int GainW = 17;
  localparam int OutW = 16;
  localparam int ProdW = 34;

  localparam logic [GainW-1:0] UnityGain = 17'h10000;

  localparam int TanhSize = 256;
  localparam int TanhLog2 = 8;
  localparam int TanhRangeLog2 = 3;
  localparam int TanhIdxW = 9;
  localparam int TanhW = 31;
  localparam int FracW = 31 + TanhRangeLog2 - TanhLog2;

  typedef logic signed [SumW-1:0] sum_t;

  typedef struct packed {
    sum_t left_sum;
    sum_t right_sum;
  } frame_t;

  typedef logic [TanhW-1:0] tanh_rom_t [0:TanhSize];

  function automatic logic [GainW-1:0] clamp_gain(input logic [GainW-1:0] g);
    return (g > UnityGain) ? UnityGain : g;
  endfunction

  // Shift-and-subtract quotient, used only while the table is built.
  function automatic longint unsigned div_u64(input longint unsigned a,
                                              input longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = (r << 1) | 64'(a[i]);
      if (r >= b) begin
        r = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Table of tanh in Q1.30, built from an exp(-2x) recurrence.
  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t rom;
    longint unsigned n;
    longint unsigned num;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned s;
    longint unsigned e;
    longint unsigned d;
    longint unsigned top;
    longint unsigned bot;
    int k;
    n = 64'(TanhSize);
    num = 64'd2 << TanhRangeLog2;
    term = 64'd1 << 31;
    pos = term;
    neg = 64'd0;
    for (k = 1; k < 40; k++) begin
      if (term != 64'd0) begin
        d = n * 64'(k);
        term = div_u64(term * num + d / 64'd2, d);
        if (k[0]) neg = neg + term;
        else pos = pos + term;
      end
    end
    s = (pos > neg) ? pos - neg : 64'd0;
    e = 64'd1 << 31;
    for (int i = 0; i <= TanhSize; i++) begin
      top = (64'd1 << 31) - e;
      bot = (64'd1 << 31) + e;
      rom[i] = TanhW'(div_u64((top << 30) + bot / 64'd2, bot));
      e = (e * s + (64'd1 << 30)) >> 31;
    end
    return rom;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/svmsl_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// svmsl_if
// Channel interfaces: voice items in, limited stereo samples out.
// ----------------------------------------------------------------------------
interface svmsl_voice_if;
  logic valid;
  logic ready;
  logic signed [svmsl_pkg::SmpW-1:0] voice_sample;
  logic [svmsl_pkg::GainW-1:0] left_gain;
  logic [svmsl_pkg::GainW-1:0] right_gain;
  logic last_voice;
  modport source (output valid, voice_sample, left_gain, right_gain, last_voice,
                  input ready);
  modport sink (input valid, voice_sample, left_gain, right_gain, last_voice,
                output ready);
endinterface

interface svmsl_mix_if;
  logic valid;
  logic ready;
  logic signed [svmsl_pkg::OutW-1:0] left_out;
  logic signed [svmsl_pkg::OutW-1:0] right_out;
  modport source (output valid, left_out, right_out, input ready);
  modport sink (input valid, left_out, right_out, output ready);
endinterface
`default_nettype wire

// ----- hdl/svmsl_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// svmsl_front
// Accepts voice items, multiplies by the gains and accumulates the frame.
// ----------------------------------------------------------------------------
module svmsl_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  svmsl_voice_if.sink          in_voice,
  output svmsl_pkg::frame_t    push_data,
  output logic                 push_valid,
  input  wire logic            push_ready
);

  logic p_valid_r;
  logic p_last_r;
  logic signed [svmsl_pkg::ProdW-1:0] pl_r;
  logic signed [svmsl_pkg::ProdW-1:0] pr_r;
  svmsl_pkg::sum_t acc_l_r;
  svmsl_pkg::sum_t acc_r_r;
  logic advance;
  logic signed [svmsl_pkg::ProdW-1:0] pl_nxt;
  logic signed [svmsl_pkg::ProdW-1:0] pr_nxt;
  svmsl_pkg::sum_t sat_l;
  svmsl_pkg::sum_t sat_r;

  function automatic svmsl_pkg::sum_t sat_add(input svmsl_pkg::sum_t a,
                                              input logic signed [svmsl_pkg::ProdW-1:0] p);
    logic signed [svmsl_pkg::SumW:0] s;
    s = (svmsl_pkg::SumW+1)'(a) + (svmsl_pkg::SumW+1)'(p);
    if (s[svmsl_pkg::SumW] != s[svmsl_pkg::SumW-1]) begin
      return s[svmsl_pkg::SumW] ? {1'b1, {(svmsl_pkg::SumW-1){1'b0}}}
                                : {1'b0, {(svmsl_pkg::SumW-1){1'b1}}};
    end
    return s[svmsl_pkg::SumW-1:0];
  endfunction

  assign advance = !p_valid_r || !p_last_r || push_ready;
  assign in_voice.ready = advance;

  assign pl_nxt = svmsl_pkg::ProdW'(in_voice.voice_sample *
                  $signed({1'b0, svmsl_pkg::clamp_gain(in_voice.left_gain)}));
  assign pr_nxt = svmsl_pkg::ProdW'(in_voice.voice_sample *
                  $signed({1'b0, svmsl_pkg::clamp_gain(in_voice.right_gain)}));

  assign sat_l = sat_add(acc_l_r, pl_r);
  assign sat_r = sat_add(acc_r_r, pr_r);

  assign push_valid = p_valid_r && p_last_r;
  assign push_data = '{left_sum: sat_l, right_sum: sat_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      acc_l_r <= '0;
      acc_r_r <= '0;
    end else begin
      if (advance) p_valid_r <= in_voice.valid;
      if (p_valid_r && advance) begin
        acc_l_r <= p_last_r ? '0 : sat_l;
        acc_r_r <= p_last_r ? '0 : sat_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_voice.valid) begin
      pl_r <= pl_nxt;
      pr_r <= pr_nxt;
      p_last_r <= in_voice.last_voice;
    end
  end

  a_clear_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    (p_valid_r && p_last_r && push_ready) |=> (acc_l_r == '0 && acc_r_r == '0))
    else $error("frame sums not cleared after close");

endmodule
`default_nettype wire

// ----- hdl/svmsl_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// svmsl_queue
// Short queue of closed frames between the accumulator and the limiter.
// ----------------------------------------------------------------------------
module svmsl_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire svmsl_pkg::frame_t push_data,
  input  wire logic              push_valid,
  output logic                   push_ready,
  output svmsl_pkg::frame_t      pop_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  svmsl_pkg::frame_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic do_push;
  logic do_pop;

  assign push_ready = count_r != CW'(DEPTH);
  assign pop_valid = count_r != '0;
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("frame queue count beyond depth");

  a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("frame queue count did not follow a push");

endmodule
`default_nettype wire

// ----- hdl/svmsl_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// svmsl_back
// Master scaling, tanh soft limiting, rounding and the output register.
// ----------------------------------------------------------------------------
module svmsl_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire svmsl_pkg::frame_t           pop_data,
  input  wire logic                        pop_valid,
  output logic                             pop_ready,
  input  wire logic [svmsl_pkg::GainW-1:0] master_gain,
  svmsl_mix_if.source                      out_mix
);

  localparam svmsl_pkg::tanh_rom_t TanhRom = svmsl_pkg::build_tanh_rom();
  localparam int MagW = svmsl_pkg::SumW;
  localparam int HalfW = MagW / 2;
  localparam int PpW = HalfW + svmsl_pkg::GainW;
  localparam int VsW = 33;
  localparam int TW = svmsl_pkg::TanhW;
  localparam int FW = svmsl_pkg::FracW;
  localparam int IW = svmsl_pkg::TanhIdxW;
  localparam int CntW = $clog2(TW);
  localparam int RoundW = TW + 15;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_SCALE  = 11'b00000000010,
    ST_MAG    = 11'b00000000100,
    ST_LOOK   = 11'b00000001000,
    ST_INTERP = 11'b00000010000,
    ST_PROD   = 11'b00000100000,
    ST_PREP   = 11'b00001000000,
    ST_DIV    = 11'b00010000000,
    ST_CONV   = 11'b00100000000,
    ST_ROUND  = 11'b01000000000,
    ST_DONE   = 11'b10000000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  logic neg_l_r;
  logic neg_r_r;
  logic [MagW-1:0] mag_l_r;
  logic [MagW-1:0] mag_r_r;
  logic [svmsl_pkg::GainW-1:0] mg_r;
  logic [PpW-1:0] pp_lh_r;
  logic [PpW-1:0] pp_ll_r;
  logic [PpW-1:0] pp_rh_r;
  logic [PpW-1:0] pp_rl_r;
  logic [MagW-1:0] lm_r;
  logic [MagW-1:0] rm_r;
  logic [TW-1:0] t_lo_r;
  logic [TW-1:0] t_hi_r;
  logic [FW-1:0] frac_r;
  logic [VsW-1:0] vs_r;
  logic [VsW-1:0] lms_r;
  logic [VsW-1:0] rms_r;
  logic zero_r;
  logic [TW-1:0] t_r;
  logic ch_r;
  logic [TW+16:0] pa_r;
  logic [TW+15:0] pb_r;
  logic [VsW-1:0] rem_r;
  logic [TW-1:0] dlo_r;
  logic [TW-1:0] q_r;
  logic [CntW-1:0] cnt_r;
  logic [RoundW-1:0] prod_r;
  logic signed [svmsl_pkg::OutW-1:0] res_l_r;
  logic signed [svmsl_pkg::OutW-1:0] res_r_r;
  logic out_valid_r;
  logic signed [svmsl_pkg::OutW-1:0] out_l_r;
  logic signed [svmsl_pkg::OutW-1:0] out_r_r;

  logic [MagW-1:0] v;
  logic [2:0] shamt;
  logic idx_sat;
  logic [IW-1:0] idx_lo;
  logic [IW-1:0] idx_hi;
  logic [57:0] lm_full;
  logic [57:0] rm_full;
  logic [TW+FW-1:0] interp;
  logic [VsW-1:0] chan;
  logic [VsW:0] rem_sh;
  logic div_ge;
  logic [63:0] dividend;
  logic [TW-1:0] quot;
  logic signed [RoundW+1:0] y;
  logic signed [RoundW+1:0] y_rnd;
  logic signed [RoundW-29:0] y_sh;
  logic signed [svmsl_pkg::OutW-1:0] y_sat;
  logic load_out;

  assign pop_ready = state_r == ST_IDLE;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_mix.ready);

  assign lm_full = {pp_lh_r, 20'b0} + 58'(pp_ll_r) + 58'd32768;
  assign rm_full = {pp_rh_r, 20'b0} + 58'(pp_rl_r) + 58'd32768;

  assign v = (lm_r > rm_r) ? lm_r : rm_r;
  assign idx_sat = |v[MagW-1:FW+svmsl_pkg::TanhLog2];
  assign idx_lo = idx_sat ? IW'(svmsl_pkg::TanhSize) : {1'b0, v[FW +: svmsl_pkg::TanhLog2]};
  assign idx_hi = idx_sat ? IW'(svmsl_pkg::TanhSize) : idx_lo + 1'b1;

  always_comb begin
    shamt = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (v[VsW+i]) shamt = 3'(i + 1);
    end
  end

  assign interp = (t_hi_r - t_lo_r) * frac_r;
  assign chan = ch_r ? rms_r : lms_r;
  assign dividend = {pa_r, 16'b0} + 64'(pb_r);
  assign rem_sh = {rem_r, dlo_r[TW-1]};
  assign div_ge = rem_sh >= {1'b0, vs_r};
  assign quot = zero_r ? '0 : q_r;

  assign y = (ch_r ? neg_r_r : neg_l_r) ? -$signed({2'b00, prod_r})
                                         : $signed({2'b00, prod_r});
  assign y_rnd = y + (RoundW+2)'(32'sd536870912);
  assign y_sh = y_rnd[RoundW+1:30];

  always_comb begin
    if (y_sh > 18'sd32767) y_sat = 16'sd32767;
    else if (y_sh < -18'sd32768) y_sat = -16'sd32768;
    else y_sat = y_sh[svmsl_pkg::OutW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (pop_valid) state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_MAG;
      ST_MAG:    state_nxt = ST_LOOK;
      ST_LOOK:   state_nxt = ST_INTERP;
      ST_INTERP: state_nxt = ST_PROD;
      ST_PROD:   state_nxt = ST_PREP;
      ST_PREP:   state_nxt = ST_DIV;
      ST_DIV:    if (cnt_r == '0) state_nxt = ST_CONV;
      ST_CONV:   state_nxt = ST_ROUND;
      ST_ROUND:  state_nxt = ch_r ? ST_DONE : ST_PROD;
      ST_DONE:   if (load_out) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_mix.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        neg_l_r <= pop_data.left_sum[MagW-1];
        neg_r_r <= pop_data.right_sum[MagW-1];
        mag_l_r <= pop_data.left_sum[MagW-1] ? MagW'(-pop_data.left_sum) : pop_data.left_sum;
        mag_r_r <= pop_data.right_sum[MagW-1] ? MagW'(-pop_data.right_sum)
                                              : pop_data.right_sum;
        mg_r <= svmsl_pkg::clamp_gain(master_gain);
      end
      ST_SCALE: begin
        pp_lh_r <= mag_l_r[MagW-1:HalfW] * mg_r;
        pp_ll_r <= mag_l_r[HalfW-1:0] * mg_r;
        pp_rh_r <= mag_r_r[MagW-1:HalfW] * mg_r;
        pp_rl_r <= mag_r_r[HalfW-1:0] * mg_r;
      end
      ST_MAG: begin
        lm_r <= lm_full[MagW+15:16];
        rm_r <= rm_full[MagW+15:16];
      end
      ST_LOOK: begin
        t_lo_r <= TanhRom[idx_lo];
        t_hi_r <= TanhRom[idx_hi];
        frac_r <= idx_sat ? '0 : v[FW-1:0];
        vs_r <= VsW'(v >> shamt);
        lms_r <= VsW'(lm_r >> shamt);
        rms_r <= VsW'(rm_r >> shamt);
        zero_r <= v == '0;
      end
      ST_INTERP: begin
        t_r <= t_lo_r + TW'(interp >> FW);
        ch_r <= 1'b0;
      end
      ST_PROD: begin
        pa_r <= t_r * chan[VsW-1:16];
        pb_r <= t_r * chan[15:0];
      end
      ST_PREP: begin
        rem_r <= dividend[63:TW];
        dlo_r <= dividend[TW-1:0];
        cnt_r <= CntW'(TW - 1);
      end
      ST_DIV: begin
        rem_r <= div_ge ? VsW'(rem_sh - {1'b0, vs_r}) : VsW'(rem_sh);
        dlo_r <= {dlo_r[TW-2:0], 1'b0};
        q_r <= {q_r[TW-2:0], div_ge};
        cnt_r <= cnt_r - 1'b1;
      end
      ST_CONV: begin
        prod_r <= quot * 15'd32767;
      end
      ST_ROUND: begin
        if (ch_r) res_r_r <= y_sat;
        else res_l_r <= y_sat;
        ch_r <= 1'b1;
      end
      ST_DONE: begin
        if (load_out) begin
          out_l_r <= res_l_r;
          out_r_r <= res_r_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_mix.valid = out_valid_r;
  assign out_mix.left_out = out_l_r;
  assign out_mix.right_out = out_r_r;

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |=> (state_r == ST_SCALE))
    else $error("limiter did not start after taking a frame");

endmodule
`default_nettype wire

// ----- hdl/stereo_voice_mix_soft_limiter_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_voice_mix_soft_limiter_unit
// Stereo voice mixer with tanh soft limiter and APB master volume.
// ----------------------------------------------------------------------------
//  Channel    Kind          Contents
//  in_voice   valid/ready   voice_sample, left_gain, right_gain, last_voice
//  out_mix    valid/ready   left_out, right_out
//  cfg_*      APB           master_gain at byte address 0
//
// Voice items are taken one per cycle when not stalled and accumulated in a
// two-stage front. Each closed frame goes through a queue to the limiter,
// which takes one frame at a time, with a shared one-bit-per-cycle divider
// for both channels. Reset is synchronous and clears sums, queue and output.
// The front stalls only when the frame queue is full on a closing item.
// ----------------------------------------------------------------------------
module stereo_voice_mix_soft_limiter_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  svmsl_voice_if.sink      in_voice,
  svmsl_mix_if.source      out_mix,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [svmsl_pkg::GainW-1:0] master_gain_r;
  svmsl_pkg::frame_t push_data;
  logic push_valid;
  logic push_ready;
  svmsl_pkg::frame_t pop_data;
  logic pop_valid;
  logic pop_ready;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {15'b0, master_gain_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_gain_r <= svmsl_pkg::UnityGain;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == 1'b0) begin
      master_gain_r <= cfg_pwdata[svmsl_pkg::GainW-1:0];
    end
  end

  svmsl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_voice   (in_voice),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  svmsl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  svmsl_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_data    (pop_data),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .master_gain (master_gain_r),
    .out_mix     (out_mix)
  );

endmodule
`default_nettype wire

// ----- bench/stereo_voice_mix_soft_limiter_unit_test.sv -----
// ----------------------------------------------------------------------------
// Stereo voice mixer with soft limiter: self-checking testbench
// Voice items are sent with random gaps and the mixed stereo samples are
// received under random and long stalls. A local model of the accumulators,
// the master volume and the interpolated tanh limiter predicts every frame,
// and each received sample pair is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module stereo_voice_mix_soft_limiter_unit_test;

  localparam int StallLimit = 4000;
  localparam int SettleCycles = 200;
  localparam logic [2:0] MasterGainAddr = 3'd0;
  localparam longint SumHigh = 64'sd549755813887;
  localparam longint SumLow = -64'sd549755813888;

  typedef struct packed {
    logic signed [svmsl_pkg::OutW-1:0] left_out;
    logic signed [svmsl_pkg::OutW-1:0] right_out;
  } mix_t;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  svmsl_voice_if voice_ch ();
  svmsl_mix_if mix_ch ();

  stereo_voice_mix_soft_limiter_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_voice(voice_ch),
    .out_mix(mix_ch),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  longint unsigned tanh_table [0:256];
  longint left_acc;
  longint right_acc;
  logic [svmsl_pkg::GainW-1:0] master_vol;
  mix_t expected_mix [$];
  int mismatch_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_cycles;
  int quiet_cycles;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic void build_tanh_table();
    longint unsigned num;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned s;
    longint unsigned e;
    longint unsigned d;
    longint unsigned top;
    longint unsigned bot;
    num = 64'd16;
    term = 64'd1 << 31;
    pos = term;
    neg = 0;
    for (int k = 1; k < 40 && term != 0; k++) begin
      d = 64'd256 * longint'(k);
      term = (term * num + d / 2) / d;
      if (k % 2 == 1) neg += term;
      else pos += term;
    end
    s = (pos > neg) ? pos - neg : 0;
    e = 64'd1 << 31;
    for (int i = 0; i <= 256; i++) begin
      top = (64'd1 << 31) - e;
      bot = (64'd1 << 31) + e;
      tanh_table[i] = ((top << 30) + bot / 2) / bot;
      e = (e * s + (64'd1 << 30)) >> 31;
    end
  endfunction

  function automatic longint unsigned limit_gain(input logic [svmsl_pkg::GainW-1:0] g);
    return (g > 17'h10000) ? 64'd65536 : longint'(g);
  endfunction

  function automatic longint clip_sum(input longint x);
    if (x > SumHigh) return SumHigh;
    if (x < SumLow) return SumLow;
    return x;
  endfunction

  function automatic logic [svmsl_pkg::OutW-1:0] round_sample(input bit negative,
                                                              input longint unsigned r);
    longint y;
    longint o;
    y = negative ? -longint'(r) : longint'(r);
    o = ((y * 32767 + (64'sd1 <<< 29) + (64'sd1 <<< 46)) >>> 30) - 65536;
    if (o > 32767) o = 32767;
    if (o < -32768) o = -32768;
    return o[svmsl_pkg::OutW-1:0];
  endfunction

  function automatic void mix_voice(input logic signed [svmsl_pkg::SmpW-1:0] smp,
                                    input logic [svmsl_pkg::GainW-1:0] lg,
                                    input logic [svmsl_pkg::GainW-1:0] rg,
                                    input logic last);
    longint unsigned lm;
    longint unsigned rm;
    longint unsigned v;
    longint unsigned t;
    longint unsigned q;
    longint unsigned idx;
    longint unsigned frac;
    longint unsigned lr;
    longint unsigned rr;
    longint unsigned mg;
    mix_t res;
    left_acc = clip_sum(left_acc + longint'(smp) * longint'(limit_gain(lg)));
    right_acc = clip_sum(right_acc + longint'(smp) * longint'(limit_gain(rg)));
    if (!last) return;
    mg = limit_gain(master_vol);
    lm = ((left_acc < 0 ? -left_acc : left_acc) * mg + 32768) >> 16;
    rm = ((right_acc < 0 ? -right_acc : right_acc) * mg + 32768) >> 16;
    v = (lm > rm) ? lm : rm;
    lr = 0;
    rr = 0;
    if (v != 0) begin
      q = v * 256;
      idx = q >> 34;
      frac = q & ((64'd1 << 34) - 1);
      if (idx >= 256) t = tanh_table[256];
      else t = tanh_table[idx] +
               (((tanh_table[idx + 1] - tanh_table[idx]) * frac) >> 34);
      while (v >= (64'd1 << 33)) begin
        v >>= 1;
        lm >>= 1;
        rm >>= 1;
      end
      lr = (t * lm) / v;
      rr = (t * rm) / v;
    end
    res.left_out = round_sample(left_acc < 0, lr);
    res.right_out = round_sample(right_acc < 0, rr);
    expected_mix.push_back(res);
    left_acc = 0;
    right_acc = 0;
  endfunction

  task automatic send_voice(input logic signed [svmsl_pkg::SmpW-1:0] smp,
                            input logic [svmsl_pkg::GainW-1:0] lg,
                            input logic [svmsl_pkg::GainW-1:0] rg,
                            input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      voice_ch.valid <= 1'b0;
      @(posedge clk);
    end
    voice_ch.valid <= 1'b1;
    voice_ch.voice_sample <= smp;
    voice_ch.left_gain <= lg;
    voice_ch.right_gain <= rg;
    voice_ch.last_voice <= last;
    @(posedge clk);
    while (!voice_ch.ready) @(posedge clk);
    mix_voice(smp, lg, rg, last);
  endtask

  task automatic write_master(input logic [svmsl_pkg::GainW-1:0] value);
    voice_ch.valid <= 1'b0;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= MasterGainAddr;
    cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    master_vol = value;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic drain();
    voice_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_mix.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic signed [svmsl_pkg::SmpW-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(signed'($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [svmsl_pkg::GainW-1:0] pick_gain();
    case ($urandom_range(7))
      0: return 17'h10000;
      1: return 17'h0;
      2: return 17'($urandom);
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  task automatic send_frames(input int item_goal);
    int sent;
    int len;
    sent = 0;
    while (sent < item_goal) begin
      len = ($urandom_range(15) == 0) ? $urandom_range(64, 1) : $urandom_range(8, 1);
      if ($urandom_range(19) == 0) len = 1;
      for (int i = 0; i < len; i++) begin
        send_voice(pick_sample(), pick_gain(), pick_gain(), i == len - 1);
      end
      sent += len;
    end
  endtask

  task automatic test_directed();
    send_voice(16'sh7fff, 17'h10000, 17'h0, 1'b1);
    send_voice(16'sh8000, 17'h0, 17'h10000, 1'b1);
    send_voice(16'sh8000, 17'h1ffff, 17'h10001, 1'b1);
    send_voice(16'sh0, 17'h10000, 17'h10000, 1'b1);
    send_voice(16'sh1, 17'h1, 17'h0, 1'b1);
    send_voice(16'shffff, 17'h0ffff, 17'h1ffff, 1'b1);
    send_voice(16'sh4000, 17'h8000, 17'h4000, 1'b0);
    send_voice(16'shc000, 17'h8000, 17'h10000, 1'b1);
    for (int i = 0; i < 12; i++) send_voice(16'sh7fff, 17'h10000, 17'h8000, i == 11);
    send_voice(16'sh5555, 17'h0aaaa, 17'h15555, 1'b1);
    drain();
  endtask

  task automatic test_sum_saturation();
    for (int i = 0; i < 260; i++) send_voice(16'sh8000, 17'h10000, 17'h1ffff, i == 259);
    for (int i = 0; i < 260; i++) send_voice(16'sh7fff, 17'h10000, 17'h0, i == 259);
    drain();
  endtask

  task automatic test_master_gain();
    logic [svmsl_pkg::GainW-1:0] settings [6];
    settings = '{17'h0, 17'h1, 17'h10000, 17'h0ffff, 17'h1ffff, 17'h0};
    settings[5] = 17'($urandom);
    foreach (settings[i]) begin
      write_master(settings[i]);
      send_frames(30);
      for (int j = 0; j < 10; j++) send_voice(16'sh7fff, 17'h10000, 17'h10000, j == 9);
      drain();
    end
    write_master(17'h10000);
  endtask

  task automatic test_random_traffic(input int snd_pct, input int rcv_pct);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    send_frames(170);
    drain();
  endtask

  task automatic test_receiver_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_cycles = 400;
    send_frames(100);
    drain();
  endtask

  always @(posedge clk) begin
    if (voice_ch.valid && voice_ch.ready || mix_ch.valid && mix_ch.ready) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    mix_t want;
    if (rst_n && mix_ch.valid && mix_ch.ready) begin
      if (expected_mix.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected transfer L=%0d R=%0d", $time,
                 mix_ch.left_out, mix_ch.right_out);
      end else begin
        want = expected_mix.pop_front();
        if (mix_ch.left_out !== want.left_out) begin
          mismatch_count++;
          $display("%0t: left_out expected %0d actual %0d", $time,
                   want.left_out, mix_ch.left_out);
        end
        if (mix_ch.right_out !== want.right_out) begin
          mismatch_count++;
          $display("%0t: right_out expected %0d actual %0d", $time,
                   want.right_out, mix_ch.right_out);
        end
      end
    end
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      mix_ch.ready <= 1'b0;
    end else begin
      mix_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    rst_n <= 1'b0;
    voice_ch.valid <= 1'b0;
    voice_ch.voice_sample <= '0;
    voice_ch.left_gain <= '0;
    voice_ch.right_gain <= '0;
    voice_ch.last_voice <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    quiet_cycles = 0;
    hold_off_cycles = 0;
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    left_acc = 0;
    right_acc = 0;
    master_vol = 17'h10000;
    build_tanh_table();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_sum_saturation();
    test_master_gain();
    test_random_traffic(19, 79);
    test_random_traffic(79, 19);
    test_random_traffic(0, 0);
    test_receiver_hold_off();
    if (mismatch_count == 0 && expected_mix.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/svmsl_pkg.sv
hdl/svmsl_if.sv
hdl/svmsl_front.sv
hdl/svmsl_queue.sv
hdl/svmsl_back.sv
hdl/stereo_voice_mix_soft_limiter_unit.sv
bench/stereo_voice_mix_soft_limiter_unit_test.sv
